// ----- design/fsf_pkg.sv -----
// types, constants and register map of the five-point stencil filter
`timescale 1ns / 1ps

package fsf_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS     = 11;
   localparam int PIXEL_BITS     = 16;
   localparam int CW_BITS        = 16;
   localparam int NW_BITS        = 14;
   localparam int FRAC_BITS      = 16;
   localparam int NSUM_BITS      = PIXEL_BITS + 2;
   localparam int ACC_BITS       = PIXEL_BITS + CW_BITS + 2;
   localparam int RND_BITS       = ACC_BITS - FRAC_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_WIDTH       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_WEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NEIGHBOR_WEIGHT = 2'd2;

   localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET       = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_MIN         = 11'd2;
   localparam logic [CW_BITS-1:0]    CENTER_WEIGHT_RESET   = 16'd39322;
   localparam logic [NW_BITS-1:0]    NEIGHBOR_WEIGHT_RESET = 14'd6554;

   localparam logic [1:0] ROWS_NONE = 2'd0;
   localparam logic [1:0] ROWS_FULL = 2'd2;

   localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } fsf_cmd_type;

   typedef struct packed {
      fsf_cmd_type           command;
      logic [PIXEL_BITS-1:0] pixel;
   } fsf_req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] filtered;
      logic                  frame_end;
   } fsf_rsp_type;

endpackage

// ----- design/five_point_stencil_filter.sv -----
// five-point stencil smoothing filter, streaming top level
//
// req channel takes one transaction per pixel in raster order, row_width
// pixels per row; a drain transaction stands for a zero pixel below the frame.
// rsp channel returns the smoothed pixel one row above the current position,
// so the first row yields nothing and the row of drains flushes the last row,
// the final drain marking frame_end. a drain before any row is dropped.
// the user must write row_width, center_weight and neighbor_weight over the
// csr port only while idle; the block itself does not enforce it. once the
// transaction that completes its window is accepted, a result passes the line
// buffer read stage and then the result register. throughput: one transaction
// per cycle while rsp does not stall; the line buffers are memories with a
// registered read, which sets the one-stage read pipeline. when rsp stalls,
// the result register holds and req_stall rises once the read stage is full.
// reset is synchronous: column and row count clear, registers take their
// defaults; line buffer contents stay undefined until rewritten.
`timescale 1ns / 1ps

module five_point_stencil_filter import fsf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  fsf_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output fsf_rsp_type               rsp_data,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];

   logic [WIDTH_BITS-1:0] row_width_ff;
   logic [CW_BITS-1:0]    center_weight_ff;
   logic [NW_BITS-1:0]    neighbor_weight_ff;

   logic [ADDR_BITS-1:0]  col_ff, col_in;
   logic [1:0]            rows_ff, rows_in;

   logic                  b_valid_ff;
   logic [ADDR_BITS-1:0]  b_col_ff;
   logic                  b_last_ff;
   logic                  b_drain_ff;
   logic                  b_produce_ff;
   logic [PIXEL_BITS-1:0] b_down_ff;
   logic [PIXEL_BITS-1:0] up_rd_ff;
   logic [PIXEL_BITS-1:0] center_rd_ff;
   logic [PIXEL_BITS-1:0] right_rd_ff;
   logic [PIXEL_BITS-1:0] left_ff;

   logic                  rsp_valid_ff;
   fsf_rsp_type           rsp_data_ff;

   logic [WIDTH_BITS-1:0] eff_width;
   logic [WIDTH_BITS-1:0] col_plus;
   logic [ADDR_BITS-1:0]  col_right;
   logic                  last;
   logic                  is_drain;
   logic                  skip;
   logic                  accept;
   logic                  take;
   logic                  b_adv;
   logic                  b_free;
   logic                  b_move;
   logic [PIXEL_BITS-1:0] down;

   logic [PIXEL_BITS-1:0]   left_val;
   logic [PIXEL_BITS-1:0]   right_val;
   logic [NSUM_BITS-1:0]    nsum;
   logic [ACC_BITS-1:0]     prod_c;
   logic [ACC_BITS-1:0]     prod_n;
   logic [ACC_BITS-1:0]     acc;
   logic [RND_BITS-1:0]     rnd;
   logic [PIXEL_BITS-1:0]   filtered;

   // position and handshake control
   always_comb begin
      if (row_width_ff < ROW_WIDTH_MIN) begin
         eff_width = ROW_WIDTH_MIN;
      end else if (row_width_ff > WIDTH_BITS'(MAX_WIDTH)) begin
         eff_width = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         eff_width = row_width_ff;
      end
   end

   assign col_plus  = WIDTH_BITS'(col_ff) + WIDTH_BITS'(1);
   assign col_right = col_plus[ADDR_BITS-1:0];
   assign last      = (col_plus >= eff_width);
   assign is_drain  = (req_data.command == CMD_DRAIN);
   assign skip      = is_drain && (rows_ff == ROWS_NONE);
   assign down      = is_drain ? '0 : req_data.pixel;

   assign b_adv     = !rsp_valid_ff || !rsp_stall;
   assign b_free    = !b_valid_ff || b_adv;
   assign b_move    = b_valid_ff && b_adv;
   assign req_stall = !b_free;
   assign accept    = req_valid && !req_stall;
   assign take      = accept && !skip;

   always_comb begin
      col_in  = col_ff;
      rows_in = rows_ff;
      if (take) begin
         if (last) begin
            col_in = '0;
            if (is_drain) begin
               rows_in = ROWS_NONE;
            end else if (rows_ff < ROWS_FULL) begin
               rows_in = rows_ff + 2'd1;
            end
         end else begin
            col_in = col_right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff       <= ROW_WIDTH_RESET;
         center_weight_ff   <= CENTER_WEIGHT_RESET;
         neighbor_weight_ff <= NEIGHBOR_WEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_ROW_WIDTH:       row_width_ff       <= csr_write_data[WIDTH_BITS-1:0];
            REG_CENTER_WEIGHT:   center_weight_ff   <= csr_write_data[CW_BITS-1:0];
            REG_NEIGHBOR_WEIGHT: neighbor_weight_ff <= csr_write_data[NW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         rows_ff      <= ROWS_NONE;
         b_valid_ff   <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
         if (b_free) begin
            b_valid_ff <= take;
         end
         if (b_move) begin
            left_ff <= center_rd_ff;
         end
         if (b_adv) begin
            rsp_valid_ff <= b_move && b_produce_ff;
         end
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         b_col_ff     <= col_ff;
         b_last_ff    <= last;
         b_drain_ff   <= is_drain;
         b_produce_ff <= (rows_ff != ROWS_NONE);
         b_down_ff    <= down;
      end
   end

   // line buffers
   always_ff @(posedge clock) begin
      if (take) begin
         center_rd_ff        <= middle_mem[col_ff];
         right_rd_ff         <= middle_mem[col_right];
         middle_mem[col_ff]  <= down;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         up_rd_ff <= upper_mem[col_ff];
      end
      if (b_move) begin
         upper_mem[b_col_ff] <= b_produce_ff ? center_rd_ff : '0;
      end
   end

   // stencil arithmetic
   always_comb begin
      left_val  = (b_col_ff == '0) ? '0 : left_ff;
      right_val = b_last_ff ? '0 : right_rd_ff;
      nsum      = NSUM_BITS'(up_rd_ff) + NSUM_BITS'(b_down_ff)
                + NSUM_BITS'(left_val) + NSUM_BITS'(right_val);
      prod_c    = ACC_BITS'(center_rd_ff) * ACC_BITS'(center_weight_ff);
      prod_n    = ACC_BITS'(nsum) * ACC_BITS'(neighbor_weight_ff);
      acc       = prod_c + prod_n + ROUND_HALF;
      rnd       = acc[ACC_BITS-1:FRAC_BITS];
      filtered  = (|rnd[RND_BITS-1:PIXEL_BITS]) ? '1 : rnd[PIXEL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         rsp_data_ff.filtered  <= filtered;
         rsp_data_ff.frame_end <= b_drain_ff && b_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_stall_needs_full_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> b_valid_ff)
      else $error("input stalled with an empty read stage");

   a_early_drain_no_state: assert property (@(posedge clock) disable iff (reset)
      (accept && skip) |=> ($stable(col_ff) && rows_ff == ROWS_NONE && !b_valid_ff))
      else $error("drain before any row changed state");

   a_row_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (take && last) |=> (col_ff == '0))
      else $error("column did not wrap at row end");

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (take && last && is_drain) |=> (rows_ff == ROWS_NONE))
      else $error("final drain did not restart the frame");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(b_valid_ff) && $past(b_produce_ff)))
      else $error("result without a producing transaction");

endmodule

// ----- tb/sv/five_point_stencil_filter_test.sv -----
// self-checking testbench for the five-point stencil smoothing filter
`timescale 1ns / 1ps

module five_point_stencil_filter_test;
   import fsf_pkg::*;

   localparam int IDLE_PERCENT  = 25;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 560;
   localparam int TAIL_WIDTH    = 64;
   localparam int HOLD_FRAME    = 4;
   localparam int QUIET_FIRST   = 10;
   localparam int QUIET_LAST    = 17;
   localparam longint TIMEOUT_NS = 2_000_000;

   typedef enum logic {
      STEP_ITEM,
      STEP_WRITE
   } step_kind_type;

   typedef struct packed {
      step_kind_type             kind;
      logic [CSR_INDEX_BITS-1:0] csr_sel;
      fsf_cmd_type               command;
      logic [CSR_DATA_BITS-1:0]  value;
      logic                      typed;
      logic [PIXEL_BITS-1:0]     typed_filtered;
      logic                      typed_frame_end;
   } directed_step_type;

   localparam int DIRECTED_STEPS = 35;
   localparam directed_step_type DIRECTED [DIRECTED_STEPS] = '{
      '{STEP_WRITE, REG_ROW_WIDTH,       CMD_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_DRAIN, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h0100, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_DRAIN, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{STEP_WRITE, REG_CENTER_WEIGHT,   CMD_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{STEP_WRITE, REG_NEIGHBOR_WEIGHT, CMD_PIXEL, 16'h3FFF, 1'b0, 16'h0000, 1'b0},
      '{STEP_WRITE, REG_ROW_WIDTH,       CMD_PIXEL, 16'h0001, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_DRAIN, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_DRAIN, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
      '{STEP_WRITE, REG_CENTER_WEIGHT,   CMD_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{STEP_WRITE, REG_NEIGHBOR_WEIGHT, CMD_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_DRAIN, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_DRAIN, 16'h0000, 1'b1, 16'h0000, 1'b1},
      '{STEP_WRITE, REG_ROW_WIDTH,       CMD_PIXEL, 16'h0003, 1'b0, 16'h0000, 1'b0},
      '{STEP_WRITE, REG_CENTER_WEIGHT,   CMD_PIXEL, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{STEP_WRITE, REG_NEIGHBOR_WEIGHT, CMD_PIXEL, 16'h1000, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'hA5A5, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h5A5A, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h1234, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'hC3C3, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h3C3C, 1'b0, 16'h0000, 1'b0},
      // shrink the row while the column is past the new end
      '{STEP_WRITE, REG_ROW_WIDTH,       CMD_PIXEL, 16'h0002, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_PIXEL, 16'h0001, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_DRAIN, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{STEP_ITEM,  '0,                  CMD_DRAIN, 16'h0000, 1'b0, 16'h0000, 1'b0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   fsf_req_type               req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   fsf_rsp_type               rsp_data;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   // filter model state and register copies
   bit   [PIXEL_BITS-1:0] upper_line  [MAX_WIDTH];
   bit   [PIXEL_BITS-1:0] middle_line [MAX_WIDTH];
   int unsigned           column_now = 0;
   int unsigned           rows_filled = 0;
   logic [PIXEL_BITS-1:0] left_tap = '0;
   logic [WIDTH_BITS-1:0] cfg_row_width = ROW_WIDTH_RESET;
   logic [CW_BITS-1:0]    cfg_center = CENTER_WEIGHT_RESET;
   logic [NW_BITS-1:0]    cfg_neighbor = NEIGHBOR_WEIGHT_RESET;

   fsf_rsp_type expected_pixels [$];
   int unsigned mismatch_count = 0;
   int unsigned accepted_items = 0;
   bit          quiet_stretch = 1'b0;
   bit          hold_request = 1'b0;

   five_point_stencil_filter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned active_width();
      if (cfg_row_width < ROW_WIDTH_MIN) return ROW_WIDTH_MIN;
      if (cfg_row_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_row_width;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] weighted_sum(logic [PIXEL_BITS-1:0] center,
                                                          logic [NSUM_BITS-1:0] around);
      longint unsigned center_term;
      longint unsigned around_term;
      longint unsigned acc;
      center_term = center;
      around_term = around;
      acc = center_term * cfg_center + around_term * cfg_neighbor;
      acc = (acc + 32768) >> FRAC_BITS;
      return (acc > 64'hFFFF) ? '1 : PIXEL_BITS'(acc);
   endfunction

   function automatic bit stencil_predict(input fsf_req_type item, output fsf_rsp_type result);
      int unsigned           width;
      int unsigned           col;
      bit                    drain;
      bit                    last;
      bit                    produced;
      logic [PIXEL_BITS-1:0] below;
      logic [PIXEL_BITS-1:0] above;
      logic [PIXEL_BITS-1:0] center;
      logic [PIXEL_BITS-1:0] left;
      logic [PIXEL_BITS-1:0] right;
      width = active_width();
      col = column_now % MAX_WIDTH;
      drain = (item.command == CMD_DRAIN);
      below = drain ? '0 : item.pixel;
      last = (col + 1 >= width);
      result = '0;
      produced = 1'b0;
      if (drain && rows_filled == 0) return 1'b0;
      above = upper_line[col];
      center = middle_line[col];
      left = (col == 0) ? '0 : left_tap;
      right = last ? '0 : middle_line[(col + 1) % MAX_WIDTH];
      left_tap = center;
      if (rows_filled == 0) begin
         upper_line[col] = '0;
      end else begin
         result.filtered = weighted_sum(center, NSUM_BITS'(above) + NSUM_BITS'(below)
                                        + NSUM_BITS'(left) + NSUM_BITS'(right));
         result.frame_end = drain && last;
         produced = 1'b1;
         upper_line[col] = center;
      end
      middle_line[col] = below;
      if (last) begin
         column_now = 0;
         if (drain) begin
            rows_filled = 0;
         end else if (rows_filled < 2) begin
            rows_filled++;
         end
      end else begin
         column_now = (col + 1) % MAX_WIDTH;
      end
      return produced;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] random_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t stencil mismatch: %s", $time, what);
   endtask

   task automatic drive_transaction(fsf_cmd_type command, logic [PIXEL_BITS-1:0] pixel,
                                    bit typed = 1'b0, fsf_rsp_type typed_result = '0);
      fsf_req_type item;
      fsf_rsp_type predicted;
      item.command = command;
      item.pixel = pixel;
      while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!(command == CMD_DRAIN && rows_filled == 0)) accepted_items++;
      if (stencil_predict(item, predicted)) begin
         expected_pixels.push_back(typed ? typed_result : predicted);
      end
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         REG_ROW_WIDTH:       cfg_row_width = value[WIDTH_BITS-1:0];
         REG_CENTER_WEIGHT:   cfg_center = value[CW_BITS-1:0];
         REG_NEIGHBOR_WEIGHT: cfg_neighbor = value[NW_BITS-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] random_weight();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   task automatic retune();
      logic [CSR_DATA_BITS-1:0] value;
      if ($urandom_range(99) < 40) begin
         value = CSR_DATA_BITS'($urandom);
         // the row may only grow before the first row of a frame
         if (rows_filled == 0 && column_now == 0) begin
            if ($urandom_range(9) == 0) begin
               value[WIDTH_BITS-1:0] = WIDTH_BITS'($urandom_range(13, 40));
            end else begin
               value[WIDTH_BITS-1:0] = WIDTH_BITS'($urandom_range(0, 12));
            end
         end else begin
            value[WIDTH_BITS-1:0] = WIDTH_BITS'($urandom_range(0, active_width()));
         end
         write_register(REG_ROW_WIDTH, value);
      end
      if ($urandom_range(99) < 40) write_register(REG_CENTER_WEIGHT, random_weight());
      if ($urandom_range(99) < 40) write_register(REG_NEIGHBOR_WEIGHT, random_weight());
   endtask

   task automatic send_frame(int unsigned rows);
      int unsigned width;
      width = active_width();
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < width; c++) drive_transaction(CMD_PIXEL, random_pixel());
      end
      for (int c = 0; c < width; c++) drive_transaction(CMD_DRAIN, random_pixel());
   endtask

   task automatic send_noise();
      int unsigned count;
      count = $urandom_range(1, 2 * active_width());
      for (int n = 0; n < count; n++) begin
         drive_transaction(($urandom_range(99) < 30) ? CMD_DRAIN : CMD_PIXEL, random_pixel());
      end
   endtask

   task automatic flush_frame();
      while (rows_filled != 0 || column_now != 0) begin
         drive_transaction((rows_filled == 0) ? CMD_PIXEL : CMD_DRAIN, random_pixel());
      end
   endtask

   always @(posedge clock) begin
      fsf_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("transaction with nothing pending, filtered %h frame_end %b",
                                      rsp_data.filtered, rsp_data.frame_end));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.filtered !== want.filtered) begin
               report_mismatch($sformatf("filtered %h, wanted %h", rsp_data.filtered,
                                         want.filtered));
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               report_mismatch($sformatf("frame_end %b, wanted %b", rsp_data.frame_end,
                                         want.frame_end));
            end
         end
      end
   end

   initial begin
      int unsigned hold_count;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_stall <= !quiet_stretch && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[five_point_stencil_filter] ERROR");
      $finish;
   end

   initial begin
      int unsigned frame_count;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < DIRECTED_STEPS; k++) begin
         if (DIRECTED[k].kind == STEP_WRITE) begin
            write_register(DIRECTED[k].csr_sel, DIRECTED[k].value);
         end else begin
            drive_transaction(DIRECTED[k].command, DIRECTED[k].value, DIRECTED[k].typed,
                              {DIRECTED[k].typed_filtered, DIRECTED[k].typed_frame_end});
         end
      end

      accepted_items = 0;
      frame_count = 0;
      while (accepted_items < RANDOM_ITEMS) begin
         quiet_stretch = (frame_count >= QUIET_FIRST && frame_count <= QUIET_LAST);
         if (frame_count == HOLD_FRAME) begin
            hold_request = 1'b1;
            send_frame(3);
         end else begin
            retune();
            if ($urandom_range(99) < 80) begin
               send_frame($urandom_range(1, 4));
            end else begin
               send_noise();
            end
         end
         frame_count++;
      end
      quiet_stretch = 1'b0;

      // one row at the widest setting, then flushed at a shorter row
      flush_frame();
      write_register(REG_ROW_WIDTH, '1);
      for (int c = 0; c < MAX_WIDTH; c++) drive_transaction(CMD_PIXEL, random_pixel());
      write_register(REG_ROW_WIDTH, CSR_DATA_BITS'(TAIL_WIDTH));
      flush_frame();

      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[five_point_stencil_filter] OK");
      end else begin
         $display("[five_point_stencil_filter] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/fsf_pkg.sv
design/five_point_stencil_filter.sv
tb/sv/five_point_stencil_filter_test.sv
